// ----- sv/msts_pkg.sv -----
// Shared types, codes and widths for the multi-slot timer scheduler.
// No dependencies; every other file of the block imports this package.
package msts_pkg;

    // Default sizing, used as the defaults of the top level parameters.
    localparam int NUM_TIMERS_DEF = 16;
    localparam int DELAY_BITS_DEF = 32;

    // Fixed field widths of the stream channels.
    localparam int OP_W       = 2;
    localparam int DELAY_IN_W = 32;
    localparam int SLOT_W     = 4;
    localparam int KIND_W     = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    // Bit positions of the input fields inside s_tdata.
    localparam int PERIODIC_BIT = DELAY_IN_W;
    localparam int SLOT_LSB     = DELAY_IN_W + 1;

    // At most this many expiry transactions are reported for one tick.
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = 5;

    // Operation codes carried on s_tuser.
    localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
    localparam logic [OP_W-1:0] OP_CANCEL   = 2'd2;

    // Result kinds carried on m_tuser.
    localparam logic [KIND_W-1:0] KIND_SCHEDULED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REJECTED  = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted input transaction
        logic scan_start;  // clear the walk state and read slot zero
        logic scan_step;   // process the current slot and move on
        logic single_do;   // carry out a schedule or cancel
        logic flush;       // emit the held expiry as the final one
    } msts_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_stall;
        logic            last_slot;
        logic            pend_valid;
        logic            out_free;
    } msts_status_t;

endpackage

// ----- sv/msts_ctrl.sv -----
// Controller state machine of the timer scheduler.
// Depends on msts_pkg for the command and status structs and the codes.
module msts_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  msts_pkg::msts_status_t status,
    output msts_pkg::msts_cmd_t    cmd
);
    import msts_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_RESULT   = 3'd2;
    localparam logic [2:0] ST_SCAN     = 3'd3;
    localparam logic [2:0] ST_FLUSH    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.op)
                    OP_TICK:
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    OP_SCHEDULE, OP_CANCEL:
                    begin
                        state_next = ST_RESULT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.single_do = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!status.scan_stall)
                begin
                    cmd.scan_step = 1'b1;
                    if (status.last_slot)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/msts_dp.sv -----
// Datapath of the timer scheduler: slot tables, countdown walk and result register.
// Depends on msts_pkg for field widths, codes and the command and status structs.
module msts_dp
#(
    parameter int NUM_TIMERS = msts_pkg::NUM_TIMERS_DEF,
    parameter int DELAY_BITS = msts_pkg::DELAY_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [msts_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [msts_pkg::OP_W-1:0]        s_tuser,
    input  msts_pkg::msts_cmd_t              cmd,
    output msts_pkg::msts_status_t           status,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [msts_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [msts_pkg::KIND_W-1:0]      m_tuser,
    output logic                             m_tlast
);
    import msts_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    // Countdown and reload tables, one write and one registered read each.
    logic [DELAY_BITS-1:0] rem_mem    [NUM_TIMERS];
    logic [DELAY_BITS-1:0] reload_mem [NUM_TIMERS];
    logic [DELAY_BITS-1:0] rd_rem_reg;
    logic [DELAY_BITS-1:0] rd_reload_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  rem_we;
    logic [IDX_W-1:0]      rem_waddr;
    logic [DELAY_BITS-1:0] rem_wdata;
    logic                  reload_we;

    // Per-slot flags.
    logic [NUM_TIMERS-1:0] busy_reg,  busy_next;
    logic [NUM_TIMERS-1:0] rearm_reg, rearm_next;

    // Captured input transaction.
    logic [OP_W-1:0]       op_reg;
    logic [DELAY_BITS-1:0] delay_reg;
    logic                  periodic_reg;
    logic [SLOT_W-1:0]     slot_reg;

    // Walk state.
    logic [IDX_W-1:0]      idx_reg,        idx_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]      pend_slot_reg,  pend_slot_next;
    logic [CNT_W-1:0]      rep_cnt_reg,    rep_cnt_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]     out_kind_reg,  out_kind_next;
    logic [SLOT_W-1:0]     out_slot_reg,  out_slot_next;
    logic                  out_last_reg,  out_last_next;

    // Helpers.
    logic [DELAY_BITS+DELAY_IN_W-1:0] delay_wide;
    logic [DELAY_BITS-1:0]            delay_cut;
    logic [DELAY_BITS-1:0]            delay_norm;
    logic [IDX_W+SLOT_W-1:0]          cancel_wide;
    logic [IDX_W-1:0]                 cancel_idx;
    logic                             cancel_ok;
    logic [IDX_W+SLOT_W-1:0]          pend_wide;
    logic [IDX_W+SLOT_W-1:0]          free_wide;
    logic [IDX_W-1:0]                 free_idx;
    logic                             free_found;
    logic                             out_free;
    logic                             cur_busy;
    logic                             cur_expire;
    logic                             cur_report;

    // Input delay cut to the table width, with zero taken as one.
    assign delay_wide = (DELAY_BITS + DELAY_IN_W)'(s_tdata[DELAY_IN_W-1:0]);
    assign delay_cut  = delay_wide[DELAY_BITS-1:0];
    assign delay_norm = (delay_cut == '0) ? DELAY_BITS'(1) : delay_cut;

    // Capture of the accepted transaction.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= s_tuser;
            delay_reg    <= delay_norm;
            periodic_reg <= s_tdata[PERIODIC_BIT];
            slot_reg     <= s_tdata[SLOT_LSB +: SLOT_W];
        end
    end

    // Lowest free slot.
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    // Cancel target, with slots beyond the table treated as idle.
    assign cancel_wide = (IDX_W + SLOT_W)'(slot_reg);
    assign cancel_idx  = cancel_wide[IDX_W-1:0];
    assign cancel_ok   = (32'(slot_reg) < 32'(NUM_TIMERS)) && busy_reg[cancel_idx];

    // Slot numbers narrowed to the result field.
    assign pend_wide = (IDX_W + SLOT_W)'(pend_slot_reg);
    assign free_wide = (IDX_W + SLOT_W)'(free_idx);

    // Current slot of the walk; read data belongs to idx_reg.
    assign out_free   = !out_valid_reg || m_tready;
    assign cur_busy   = busy_reg[idx_reg];
    assign cur_expire = cur_busy && (rd_rem_reg == DELAY_BITS'(1));
    assign cur_report = cur_expire && (rep_cnt_reg < CNT_W'(MAX_RESULTS));

    // Read address runs one slot ahead when the walk advances.
    always_comb
    begin
        if (cmd.scan_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.scan_step && (idx_reg != LAST_IDX))
        begin
            rd_addr = idx_reg + 1'b1;
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    // Next values of flags, walk state and result register.
    always_comb
    begin
        busy_next       = busy_reg;
        rearm_next      = rearm_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        rep_cnt_next    = rep_cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        rem_we          = 1'b0;
        rem_waddr       = idx_reg;
        rem_wdata       = rd_rem_reg - DELAY_BITS'(1);
        reload_we       = 1'b0;

        if (cmd.scan_start)
        begin
            idx_next        = '0;
            pend_valid_next = 1'b0;
            rep_cnt_next    = '0;
        end

        // One slot of the countdown walk.
        if (cmd.scan_step)
        begin
            if (idx_reg != LAST_IDX)
            begin
                idx_next = idx_reg + 1'b1;
            end
            if (cur_busy)
            begin
                rem_we = 1'b1;
                if (cur_expire)
                begin
                    if (rearm_reg[idx_reg])
                    begin
                        rem_wdata = rd_reload_reg;
                    end
                    else
                    begin
                        busy_next[idx_reg]  = 1'b0;
                        rearm_next[idx_reg] = 1'b0;
                    end
                end
            end
            if (cur_report)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_EXPIRED;
                    out_slot_next  = pend_wide[SLOT_W-1:0];
                    out_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_slot_next  = idx_reg;
                rep_cnt_next    = rep_cnt_reg + 1'b1;
            end
        end

        // Final expiry of a tick.
        if (cmd.flush)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_EXPIRED;
            out_slot_next   = pend_wide[SLOT_W-1:0];
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end

        // Schedule or cancel, each with a single result.
        if (cmd.single_do)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b1;
            if (op_reg == OP_SCHEDULE)
            begin
                if (free_found)
                begin
                    busy_next[free_idx]  = 1'b1;
                    rearm_next[free_idx] = periodic_reg;
                    rem_we               = 1'b1;
                    rem_waddr            = free_idx;
                    rem_wdata            = delay_reg;
                    reload_we            = 1'b1;
                    out_kind_next        = KIND_SCHEDULED;
                    out_slot_next        = free_wide[SLOT_W-1:0];
                end
                else
                begin
                    out_kind_next = KIND_REJECTED;
                    out_slot_next = '0;
                end
            end
            else
            begin
                if (cancel_ok)
                begin
                    busy_next[cancel_idx]  = 1'b0;
                    rearm_next[cancel_idx] = 1'b0;
                    out_kind_next          = KIND_CANCELLED;
                end
                else
                begin
                    out_kind_next = KIND_REJECTED;
                end
                out_slot_next = slot_reg;
            end
        end
    end

    // Table memories.
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[rem_waddr] <= rem_wdata;
        end
        if (reload_we)
        begin
            reload_mem[free_idx] <= delay_reg;
        end
        rd_rem_reg    <= rem_mem[rd_addr];
        rd_reload_reg <= reload_mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= '0;
            rearm_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            rep_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            rearm_reg      <= rearm_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            rep_cnt_reg    <= rep_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        out_kind_reg  <= out_kind_next;
        out_slot_reg  <= out_slot_next;
        out_last_reg  <= out_last_next;
    end

    // Status toward the controller.
    assign status.op         = op_reg;
    assign status.scan_stall = cur_report && pend_valid_reg && !out_free;
    assign status.last_slot  = (idx_reg == LAST_IDX);
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    // Result channel.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_slot_reg);
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- sv/multi_slot_timer_scheduler_unit.sv -----
// Top level of the multi-slot timer scheduler: controller plus datapath.
// Depends on msts_pkg, msts_ctrl and msts_dp.
//
//  Channel   Direction  tdata (low bit up)                       tuser       tlast
//  s_        in         delay[31:0], periodic, slot[3:0], 0 pad  operation   -
//  m_        out        slot_index[3:0], 0 pad                   kind        last_result
//
// A tick walks the slot table through the single read port of the countdown memory,
// one slot per clock while the result register does not stall the walk.
// A schedule or cancel waits for a free result register; an undefined operation gives no result.
// Reset frees every slot at once; the countdown and reload tables need no clearing.
// A stalled result register holds the walk at the next slot that expires.
module multi_slot_timer_scheduler_unit
#(
    parameter int NUM_TIMERS = msts_pkg::NUM_TIMERS_DEF,
    parameter int DELAY_BITS = msts_pkg::DELAY_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // delay[31:0], periodic, slot[3:0], zero pad
    input  logic [msts_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[1:0]
    input  logic [msts_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot_index[3:0], zero pad
    output logic [msts_pkg::M_TDATA_W-1:0] m_tdata,
    // kind[1:0]
    output logic [msts_pkg::KIND_W-1:0]    m_tuser,
    output logic                           m_tlast
);
    import msts_pkg::*;

    msts_cmd_t    cmd;
    msts_status_t status;

    // Sequencing.
    msts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Slot tables and result register.
    msts_dp
    #(
        .NUM_TIMERS (NUM_TIMERS),
        .DELAY_BITS (DELAY_BITS)
    )
    u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- test/timer_event_checker.sv -----
// Checker for the multi-slot timer scheduler: watches both stream channels,
// keeps its own copy of the timer table and compares every result transaction.
// Depends on msts_pkg for field widths, operation codes and result kinds.
module timer_event_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [msts_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [msts_pkg::OP_W-1:0]      s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [msts_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [msts_pkg::KIND_W-1:0]    m_tuser,
    input  logic                           m_tlast,
    output int                             pending_count,
    output int                             fail_count
);

    import msts_pkg::*;

    localparam int NT = NUM_TIMERS_DEF;
    localparam int DW = DELAY_BITS_DEF;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } timer_event_t;

    // Shadow copy of the timer table.
    logic [DW-1:0] ticks_left [NT];
    logic [DW-1:0] reload_span [NT];
    logic          rearm [NT];
    logic          busy [NT];

    // Events predicted but not yet seen on the result channel, oldest first.
    timer_event_t  pending_events [$];
    int            mismatches;

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
        begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    task automatic push_event(input logic [KIND_W-1:0] kind, input int slot,
                              input logic last);
        timer_event_t ev;
        ev.kind = kind;
        ev.slot = slot[SLOT_W-1:0];
        ev.last = last;
        pending_events.push_back(ev);
    endtask

    // Updates the shadow table for one accepted request and queues its events.
    task automatic apply_request(input logic [OP_W-1:0] op,
                                 input logic [S_TDATA_W-1:0] req);
        logic [DW-1:0]     span;
        logic [SLOT_W-1:0] target;
        int                hit_slot [MAX_RESULTS];
        int                hits;
        int                free_slot;
        span      = req[DW-1:0];
        target    = req[SLOT_LSB +: SLOT_W];
        hits      = 0;
        free_slot = -1;
        if (op == OP_TICK)
        begin
            // Count every armed slot down; expiries are reported in slot order.
            for (int i = 0; i < NT; i++)
            begin
                if (busy[i])
                begin
                    ticks_left[i] = ticks_left[i] - 1'b1;
                    if (ticks_left[i] == '0)
                    begin
                        if (rearm[i])
                        begin
                            ticks_left[i] = reload_span[i];
                        end
                        else
                        begin
                            busy[i]  = 1'b0;
                            rearm[i] = 1'b0;
                        end
                        if (hits < MAX_RESULTS)
                        begin
                            hit_slot[hits] = i;
                            hits++;
                        end
                    end
                end
            end
            for (int k = 0; k < hits; k++)
            begin
                push_event(KIND_EXPIRED, hit_slot[k], k == hits - 1);
            end
        end
        else if (op == OP_SCHEDULE)
        begin
            // A zero delay arms the slot for a single tick.
            if (span == '0)
            begin
                span = 1;
            end
            for (int i = NT - 1; i >= 0; i--)
            begin
                if (!busy[i])
                begin
                    free_slot = i;
                end
            end
            if (free_slot < 0)
            begin
                push_event(KIND_REJECTED, 0, 1'b1);
            end
            else
            begin
                busy[free_slot]        = 1'b1;
                rearm[free_slot]       = req[PERIODIC_BIT];
                ticks_left[free_slot]  = span;
                reload_span[free_slot] = span;
                push_event(KIND_SCHEDULED, free_slot, 1'b1);
            end
        end
        else if (op == OP_CANCEL)
        begin
            if (int'(target) < NT && busy[target])
            begin
                busy[target]       = 1'b0;
                rearm[target]      = 1'b0;
                ticks_left[target] = '0;
                push_event(KIND_CANCELLED, int'(target), 1'b1);
            end
            else
            begin
                push_event(KIND_REJECTED, int'(target), 1'b1);
            end
        end
    endtask

    // Compares one accepted result transaction with the oldest prediction.
    task automatic check_event();
        timer_event_t want;
        if (pending_events.size() == 0)
        begin
            report_mismatch("result with nothing expected, kind", int'(m_tuser), -1);
        end
        else
        begin
            want = pending_events.pop_front();
            if (m_tuser !== want.kind)
            begin
                report_mismatch("result kind", int'(m_tuser), int'(want.kind));
            end
            if (m_tdata !== {{(M_TDATA_W-SLOT_W){1'b0}}, want.slot})
            begin
                report_mismatch("result slot_index", int'(m_tdata), int'(want.slot));
            end
            if (m_tlast !== want.last)
            begin
                report_mismatch("result last_result", int'(m_tlast), int'(want.last));
            end
        end
    endtask

    // Sample both channels at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NT; i++)
            begin
                ticks_left[i]  = '0;
                reload_span[i] = '0;
                rearm[i]       = 1'b0;
                busy[i]        = 1'b0;
            end
            pending_events.delete();
            mismatches = 0;
            pending_count <= 0;
            fail_count    <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tuser, s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                check_event();
            end
            pending_count <= pending_events.size();
            fail_count    <= mismatches;
        end
    end

endmodule

// ----- test/testbench.sv -----
// Top of the timer scheduler testbench: clock, reset, request and result
// handshakes, and the verdict. Depends on msts_pkg, timer_event_checker and
// multi_slot_timer_scheduler_unit.
module testbench;

    import msts_pkg::*;

    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int CHUNKS      = 8;
    localparam int CHUNK_ITEMS = 37;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;

    int                    pending_count;
    int                    fail_count;
    int                    cycle_count;
    bit                    tx_steady;
    bit                    rx_steady;
    bit                    hold_req;

    multi_slot_timer_scheduler_unit u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    timer_event_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .pending_count (pending_count),
        .fail_count    (fail_count)
    );

    // Clock with a period of two time units.
    always #1 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offers one request transaction after a random gap and waits until it is taken.
    task automatic offer_request(input logic [OP_W-1:0] op, input logic [31:0] span,
                                 input logic rearm, input logic [SLOT_W-1:0] target);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, target, rearm, span};
        do @(posedge clk); while (!s_tready);
    endtask

    // Random request: mostly short delays so that slots expire and get reused.
    task automatic random_request();
        int            pick;
        int            span_sel;
        logic [31:0]   span;
        logic [OP_W-1:0] op;
        pick     = $urandom_range(0, 99);
        span_sel = $urandom_range(0, 9);
        if (span_sel < 7)
        begin
            span = $urandom_range(0, 5);
        end
        else if (span_sel < 9)
        begin
            span = $urandom_range(6, 60);
        end
        else
        begin
            span = $urandom;
        end
        if (pick < 45)
        begin
            op   = OP_TICK;
            span = $urandom;
        end
        else if (pick < 78)
        begin
            op = OP_SCHEDULE;
        end
        else if (pick < 95)
        begin
            op = OP_CANCEL;
        end
        else
        begin
            op = OP_UNDEFINED;
        end
        offer_request(op, span, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    endtask

    // Stops offering until every predicted result has come back.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
    endtask

    // Result side: random back-pressure, steady stretches and one long hold-off.
    initial
    begin : result_sink
        int gap;
        int taken;
        taken = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = rx_steady ? 0 : $urandom_range(0, 13);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
            if (taken % 40 == 0)
            begin
                rx_steady = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // Request side: directed sequence, random chunks, then the verdict.
    initial
    begin : request_source
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_TICK;
        cycle_count = 0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        hold_req    = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table: a tick gives nothing, a cancel is rejected, op 3 is ignored.
        offer_request(OP_TICK, 32'hFFFF_FFFF, 1'b1, 4'hF);
        offer_request(OP_CANCEL, 32'hFFFF_FFFF, 1'b1, 4'hF);
        offer_request(OP_UNDEFINED, 32'hFFFF_FFFF, 1'b1, 4'hF);

        // Zero delay acts as one, the largest delay, and a short periodic timer.
        offer_request(OP_SCHEDULE, 32'h0, 1'b0, 4'hF);
        offer_request(OP_SCHEDULE, 32'hFFFF_FFFF, 1'b1, 4'h0);
        offer_request(OP_SCHEDULE, 32'h2, 1'b1, 4'h0);
        offer_request(OP_TICK, 32'h0, 1'b0, 4'h0);
        offer_request(OP_TICK, 32'h0, 1'b0, 4'h0);
        offer_request(OP_CANCEL, 32'h0, 1'b0, 4'h1);
        offer_request(OP_CANCEL, 32'hFFFF_FFFF, 1'b1, 4'h0);

        // Fill the table, get one rejection, then expire all sixteen slots at once.
        for (int i = 0; i < 15; i++)
        begin
            offer_request(OP_SCHEDULE, 32'h2, 1'(i % 2), 4'($urandom_range(0, 15)));
        end
        offer_request(OP_SCHEDULE, 32'h5, 1'b1, 4'h3);
        offer_request(OP_TICK, 32'h0, 1'b0, 4'h0);
        offer_request(OP_TICK, 32'h0, 1'b0, 4'h0);

        // Random traffic in chunks with different idling patterns.
        for (int c = 0; c < CHUNKS; c++)
        begin
            tx_steady = ($urandom_range(0, 3) == 0);
            if (c == 2)
            begin
                hold_req  = 1'b1;
                tx_steady = 1'b1;
            end
            for (int n = 0; n < CHUNK_ITEMS; n++)
            begin
                random_request();
            end
            if (c == 4 || c == 6)
            begin
                pause_until_drained();
            end
        end
        tx_steady = 1'b0;
        s_tvalid <= 1'b0;

        // Drain, then leave room for a tick walk that may still be running.
        do @(posedge clk); while (pending_count != 0);
        repeat (NUM_TIMERS_DEF + 8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
